// ----- hdl/stbs_pkg.sv -----
// shared types and constants for the sorted table binary search block
package stbs_pkg;

  localparam int unsigned TableDepth = 128;
  localparam int unsigned ValueWidth = 16;
  localparam int unsigned IndexWidth = 7;
  localparam int unsigned LenWidth   = 8;
  localparam int unsigned QueueDepth = 2;

  localparam logic [LenWidth-1:0] LenReset = LenWidth'(1);

  // opcode field codes
  localparam logic OpcWrite  = 1'b0;
  localparam logic OpcSearch = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_DROP   = 2'd2
  } stbs_kind_e;

  typedef struct packed {
    logic                          opcode;
    logic [IndexWidth-1:0]         entry_index;
    logic signed [ValueWidth-1:0]  entry_value;
    logic signed [ValueWidth-1:0]  search_key;
  } stbs_in_t;

  typedef struct packed {
    logic                  found;
    logic [IndexWidth-1:0] found_index;
  } stbs_out_t;

  // classified item handed from the front end to the search engine
  typedef struct packed {
    stbs_kind_e                    kind;
    logic [IndexWidth-1:0]         index;
    logic signed [ValueWidth-1:0]  operand;
  } stbs_op_t;

endpackage

// ----- hdl/sorted_table_binary_search.sv -----
// top level of the sorted table binary search block
//
// input channel (in_valid_i / in_ready_o / in_data_i) takes write and search
// items. a write stores entry_value at entry_index and gives no result; an
// index past the table end is ignored. a search bisects the first
// array_length entries for search_key and gives one result item on the
// output channel (out_valid_o / out_ready_i / out_data_o): found and the
// matching index, or found low and index zero.
// array_length is set through cfg_we_i / cfg_wdata_i; the user must write it
// only while the block is idle, the block itself does not enforce this.
// items pass a two-entry queue, then the search engine. a write retires when
// the engine accepts it. a search makes at most ceil(log2(n+1)) probes for n
// covered entries, one after another on the single table read port. a result
// is loaded into the output register when its search ends, or waits in the
// engine while that register is still full.
// reset sets array_length to one and empties the queue; table contents stay
// undefined until written. a stalled receiver holds the result register, the
// engine waits with its next result, and the queue fills before in_ready_o
// drops.
module sorted_table_binary_search import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  stbs_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output stbs_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [LenWidth-1:0] cfg_wdata_i
);

  logic [LenWidth-1:0] array_length_q, array_length_d;
  logic                push_valid, push_ready;
  stbs_op_t            push_op;
  logic                pop_valid, pop_ready;
  stbs_op_t            pop_op;

  assign array_length_d = cfg_we_i ? cfg_wdata_i : array_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      array_length_q <= LenReset;
    end else begin
      array_length_q <= array_length_d;
    end
  end

  stbs_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_valid_o (push_valid),
    .q_ready_i (push_ready),
    .q_op_o    (push_op)
  );

  stbs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_op_i   (push_op),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_op_o    (pop_op)
  );

  stbs_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (pop_valid),
    .op_ready_o    (pop_ready),
    .op_i          (pop_op),
    .array_length_i(array_length_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

// ----- hdl/stbs_front.sv -----
// front end: accepts input items and classifies them into write, search or drop
module stbs_front import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepth
) (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  stbs_in_t in_data_i,
  output logic     q_valid_o,
  input  logic     q_ready_i,
  output stbs_op_t q_op_o
);

  logic in_range;

  assign in_range   = (32'(in_data_i.entry_index) < TABLE_DEPTH);
  assign q_valid_o  = in_valid_i;
  assign in_ready_o = q_ready_i;

  always_comb begin
    q_op_o.index = in_data_i.entry_index;
    if (in_data_i.opcode == OpcSearch) begin
      q_op_o.kind    = KIND_SEARCH;
      q_op_o.operand = in_data_i.search_key;
    end else begin
      // writes past the table end are dropped here
      q_op_o.kind    = in_range ? KIND_WRITE : KIND_DROP;
      q_op_o.operand = in_data_i.entry_value;
    end
  end

endmodule

// ----- hdl/stbs_fifo.sv -----
// short queue of classified items between front end and search engine
module stbs_fifo import stbs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  stbs_op_t push_op_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output stbs_op_t pop_op_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  stbs_op_t            slot_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_op_o     = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// ----- hdl/stbs_back.sv -----
// search engine: table memory, one bisection probe per cycle, result register
module stbs_back import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_valid_i,
  output logic                op_ready_o,
  input  stbs_op_t            op_i,
  input  logic [LenWidth-1:0] array_length_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output stbs_out_t           out_data_o
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PROBE = 3'b010,
    ST_HOLD  = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  logic [CntW-1:0]              lo_q, lo_d;
  logic [CntW-1:0]              hi_q, hi_d;
  logic [CntW-1:0]              mid_q, mid_d;
  logic [CntW-1:0]              len_sat;
  logic signed [ValueWidth-1:0] key_q, key_d;
  logic signed [ValueWidth-1:0] rdata_q;
  logic signed [ValueWidth-1:0] mem [TABLE_DEPTH];
  stbs_out_t                    res_q, res_d;
  stbs_out_t                    fin_res;
  logic                         fin;
  logic                         mem_we;
  logic                         out_free;
  logic                         out_load;
  stbs_out_t                    out_load_data;
  logic                         out_valid_q, out_valid_d;
  stbs_out_t                    out_data_q, out_data_d;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    if (32'(array_length_i) > TABLE_DEPTH) begin
      len_sat = CntW'(TABLE_DEPTH);
    end else begin
      len_sat = CntW'(array_length_i);
    end
  end

  always_comb begin
    state_d       = state_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    mid_d         = mid_q;
    key_d         = key_q;
    res_d         = res_q;
    fin           = 1'b0;
    fin_res       = '0;
    mem_we        = 1'b0;
    op_ready_o    = 1'b0;
    out_load      = 1'b0;
    out_load_data = res_q;

    case (state_q)
      ST_IDLE: begin
        op_ready_o = 1'b1;
        if (op_valid_i) begin
          case (op_i.kind)
            KIND_WRITE: begin
              mem_we = 1'b1;
            end
            KIND_SEARCH: begin
              key_d = op_i.operand;
              lo_d  = '0;
              hi_d  = len_sat;
              if (len_sat == '0) begin
                fin = 1'b1;
              end else begin
                mid_d   = (len_sat - CntW'(1)) >> 1;
                state_d = ST_PROBE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_PROBE: begin
        // rdata_q holds the entry at mid_q; hi is kept one past the last candidate
        if (rdata_q == key_q) begin
          fin                 = 1'b1;
          fin_res.found       = 1'b1;
          fin_res.found_index = IndexWidth'(mid_q);
        end else begin
          if (rdata_q < key_q) begin
            lo_d = mid_q + CntW'(1);
          end else begin
            hi_d = mid_q;
          end
          if (lo_d < hi_d) begin
            mid_d = lo_d + ((hi_d - lo_d - CntW'(1)) >> 1);
          end else begin
            fin = 1'b1;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_data = res_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        out_load      = 1'b1;
        out_load_data = fin_res;
        state_d       = ST_IDLE;
      end else begin
        res_d   = fin_res;
        state_d = ST_HOLD;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = out_load_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    key_q      <= key_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AddrW'(op_i.index)] <= op_i.operand;
    end
    rdata_q <= mem[mid_d[AddrW-1:0]];
  end

endmodule

// ----- test/sorted_table_binary_search_test.sv -----
// testbench for the sorted table binary search block
module sorted_table_binary_search_test;
  import stbs_pkg::*;

  localparam int CycleLimit  = 1000000;
  localparam int SettleWait  = 16;
  localparam int HoldCycles  = 80;
  localparam int TargetItems = 1550;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  stbs_in_t in_data;
  logic out_valid;
  logic out_ready;
  stbs_out_t out_data;
  logic cfg_we;
  logic [LenWidth-1:0] cfg_wdata;

  // mirror of the table and the length register
  logic signed [ValueWidth-1:0] store_model [TableDepth];
  logic [LenWidth-1:0] span_model;
  stbs_out_t lookup_answers [$];

  int error_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  bit eager = 1'b0;
  bit hold_sink = 1'b0;

  sorted_table_binary_search uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic stbs_out_t bisect_lookup(logic signed [ValueWidth-1:0] key);
    stbs_out_t ans;
    int low;
    int high;
    int mid;
    ans = '0;
    low = 0;
    high = ((int'(span_model) > TableDepth) ? TableDepth : int'(span_model)) - 1;
    while (low <= high) begin
      mid = low + (high - low) / 2;
      if (store_model[mid] == key) begin
        ans.found = 1'b1;
        ans.found_index = mid[IndexWidth-1:0];
        return ans;
      end else if (store_model[mid] < key) begin
        low = mid + 1;
      end else begin
        high = mid - 1;
      end
    end
    return ans;
  endfunction

  function automatic stbs_in_t write_item(int idx, logic signed [ValueWidth-1:0] val);
    stbs_in_t it;
    it.opcode = OpcWrite;
    it.entry_index = idx[IndexWidth-1:0];
    it.entry_value = val;
    it.search_key = ValueWidth'($urandom);
    return it;
  endfunction

  function automatic stbs_in_t search_item(logic signed [ValueWidth-1:0] key);
    stbs_in_t it;
    it.opcode = OpcSearch;
    it.entry_index = IndexWidth'($urandom);
    it.entry_value = ValueWidth'($urandom);
    it.search_key = key;
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    if (eager) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(input stbs_in_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (it.opcode == OpcWrite) begin
      store_model[it.entry_index] = it.entry_value;
    end else begin
      lookup_answers.push_back(bisect_lookup(it.search_key));
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (lookup_answers.size() != 0) @(negedge clk);
    // a trailing write may still be in flight
    repeat (SettleWait) @(negedge clk);
  endtask

  task automatic program_span(input int len);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = len[LenWidth-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    span_model = len[LenWidth-1:0];
  endtask

  task automatic load_sorted(input int count);
    int v;
    int step_max;
    if ($urandom_range(0, 1) == 0) v = -32768;
    else v = -32768 + $urandom_range(0, 65535);
    case ($urandom_range(0, 3))
      0: step_max = 1;
      1: step_max = 16;
      2: step_max = 300;
      default: step_max = 1000;
    endcase
    for (int i = 0; i < count; i++) begin
      if (v > 32767) v = 32767;
      send_item(write_item(i, v[ValueWidth-1:0]));
      v += $urandom_range(0, step_max);
    end
  endtask

  function automatic logic signed [ValueWidth-1:0] pick_key();
    int n;
    int r;
    int idx;
    n = (int'(span_model) > TableDepth) ? TableDepth : int'(span_model);
    r = $urandom_range(0, 9);
    if (n == 0 || r > 6) return ValueWidth'($urandom);
    idx = $urandom_range(0, n - 1);
    if (r < 5) return store_model[idx];
    if (r == 5) return store_model[idx] + 16'sd1;
    return store_model[idx] - 16'sd1;
  endfunction

  // keeps the table ascending around the rewritten entry
  task automatic rewrite_entry();
    int idx;
    int lo;
    int hi;
    idx = $urandom_range(0, TableDepth - 1);
    lo = (idx == 0) ? -32768 : int'(store_model[idx-1]);
    hi = (idx == TableDepth - 1) ? 32767 : int'(store_model[idx+1]);
    if (hi < lo) hi = lo;
    send_item(write_item(idx, ValueWidth'(lo + $urandom_range(0, hi - lo))));
  endtask

  // result checker
  always @(posedge clk) begin
    stbs_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (lookup_answers.size() == 0) begin
        $error("result item with no search pending: found=%0d found_index=%0d",
               out_data.found, out_data.found_index);
        error_count++;
      end else begin
        want = lookup_answers.pop_front();
        if (out_data.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_data.found);
          error_count++;
        end
        if (out_data.found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index,
                 out_data.found_index);
          error_count++;
        end
      end
    end
  end

  // result sink with random stalls and one long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_sink = 1'b0;
      end else if (eager) begin
        out_ready = 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
        out_ready = 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end else begin
        out_ready = ($urandom_range(0, 99) < 70);
      end
    end
  end

  task automatic test_table_load();
    int v;
    // full ascending table spanning the whole value range
    v = -32768;
    for (int i = 0; i < TableDepth; i++) begin
      if (i == TableDepth - 1) v = 32767;
      send_item(write_item(i, v[ValueWidth-1:0]));
      v += $urandom_range(1, 515);
    end
  endtask

  task automatic test_reset_length();
    send_item(search_item(store_model[0]));
    send_item(search_item(store_model[1]));
  endtask

  task automatic test_span_extremes();
    program_span(TableDepth);
    send_item(search_item(store_model[0]));
    send_item(search_item(store_model[TableDepth-1]));
    send_item(search_item(store_model[63]));
    send_item(search_item(store_model[40] + 16'sd1));
    // length past the table saturates
    program_span(255);
    send_item(search_item(store_model[TableDepth-1]));
    send_item(search_item(store_model[100]));
    program_span(200);
    send_item(search_item(store_model[127]));
    // no entries covered
    program_span(0);
    send_item(search_item(store_model[0]));
    send_item(search_item(16'sh8000));
  endtask

  task automatic test_unsorted_table();
    program_span(8);
    for (int i = 0; i < 8; i++) send_item(write_item(i, ValueWidth'($urandom)));
    for (int i = 0; i < 5; i++) send_item(search_item(pick_key()));
  endtask

  task automatic test_backpressure();
    program_span(TableDepth);
    eager = 1'b1;
    hold_sink = 1'b1;
    for (int i = 0; i < 24; i++) send_item(search_item(pick_key()));
    eager = 1'b0;
    drain();
  endtask

  task automatic test_random_traffic();
    int span;
    int n;
    while (items_sent < TargetItems) begin
      case ($urandom_range(0, 9))
        0: span = 0;
        1: span = TableDepth;
        2: span = $urandom_range(TableDepth + 1, 255);
        3: span = $urandom_range(1, TableDepth);
        default: span = $urandom_range(1, 24);
      endcase
      program_span(span);
      eager = ($urandom_range(0, 3) == 0);
      n = (span > TableDepth) ? TableDepth : span;
      if ($urandom_range(0, 9) < 6) begin
        load_sorted(n);
      end else if ($urandom_range(0, 3) == 0) begin
        // a few arbitrary values break the ordering
        repeat ($urandom_range(1, 6))
          send_item(write_item($urandom_range(0, TableDepth - 1), ValueWidth'($urandom)));
      end
      repeat ($urandom_range(20, 60)) begin
        if ($urandom_range(0, 19) == 0) rewrite_entry();
        else send_item(search_item(pick_key()));
      end
      eager = 1'b0;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    span_model = LenReset;
    for (int i = 0; i < TableDepth; i++) store_model[i] = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_table_load();
    test_reset_length();
    test_span_extremes();
    test_unsorted_table();
    test_backpressure();
    test_random_traffic();

    drain();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/stbs_pkg.sv
hdl/stbs_front.sv
hdl/stbs_fifo.sv
hdl/stbs_back.sv
hdl/sorted_table_binary_search.sv
test/sorted_table_binary_search_test.sv
